// ===== design/i2cm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, codes and timing constants of the i2c master bit sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // command kinds (codes above wait ack behave as tick)
  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_START    = 3'd1;
  localparam logic [2:0] KIND_STOP     = 3'd2;
  localparam logic [2:0] KIND_WRITE    = 3'd3;
  localparam logic [2:0] KIND_READ     = 3'd4;
  localparam logic [2:0] KIND_WAIT_ACK = 3'd5;

  // configuration register indexes
  localparam logic REG_TICKS_PER_US = 1'b0;
  localparam logic REG_ACK_TIMEOUT  = 1'b1;

  // configuration reset values
  localparam logic [7:0] TICKS_PER_US_RESET = 8'd1;
  localparam logic [7:0] ACK_TIMEOUT_RESET  = 8'd250;

  // number of data bits in a byte
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // bus sequencing phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_STA_A,
    PH_STA_B,
    PH_STO_A,
    PH_STO_B,
    PH_WA_A,
    PH_WA_B,
    PH_WA_POLL,
    PH_WR_LOW,
    PH_WR_HIGH,
    PH_RD_LOW,
    PH_RD_HIGH,
    PH_RA_LOW,
    PH_RA_HIGH
  } phase_t;

  // one input item
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_data;
    logic       ack_after_read;
    logic       sda_line;
  } item_t;

  // one result item
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       no_ack;
    logic       rejected;
  } result_t;

  // hold time of each phase in microseconds
  function automatic logic [3:0] phase_delay(phase_t ph);
    logic [3:0] d;
    case (ph)
      PH_STA_A, PH_STA_B, PH_STO_A, PH_STO_B: d = 4'd4;
      PH_WA_A, PH_WA_B:                       d = 4'd1;
      PH_WR_LOW, PH_WR_HIGH,
      PH_RD_LOW, PH_RD_HIGH:                  d = 4'd5;
      PH_RA_LOW, PH_RA_HIGH:                  d = 4'd2;
      default:                                d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== design/i2c_master_bit_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master bit sequencer: input register, combinational state update, result
// register. Ticks and commands drive SCL/SDA and report status per item.
// Path: an accepted item passes the input register, then the result register,
//   where out_valid rises; a stalled result side holds it in the input register.
// Throughput: one item per cycle while the result side is not stalled; the state update is combinational.
// Reset: synchronous; bus released high with SDA driven, idle, config defaults.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] kind,
  input  logic [7:0] tx_data,
  input  logic       ack_after_read,
  input  logic       sda_line,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_out,
  output logic       sda_out,
  output logic       sda_drive,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] rx_data,
  output logic       no_ack,
  output logic       rejected,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import i2cm_pkg::*;

  logic       in_full;
  item_t      item_q;
  logic       out_full;
  result_t    res_q;
  result_t    result_next;
  logic       out_free;
  logic       in_fire;
  logic       step;
  logic [7:0] ticks_per_us;
  logic [7:0] ack_timeout;

  // handshake control
  assign out_free  = !out_full || !out_stall;
  assign in_stall  = in_full && !out_free;
  assign in_fire   = in_valid && !in_stall;
  assign step      = in_full && out_free;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= TICKS_PER_US_RESET;
      ack_timeout  <= ACK_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TICKS_PER_US) begin
        ticks_per_us <= cfg_data;
      end else begin
        ack_timeout <= cfg_data;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_fire) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_q.kind           <= kind;
      item_q.tx_data        <= tx_data;
      item_q.ack_after_read <= ack_after_read;
      item_q.sda_line       <= sda_line;
    end
  end

  // sequencer state and update
  i2cm_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .item         (item_q),
    .ticks_per_us (ticks_per_us),
    .ack_timeout  (ack_timeout),
    .result_next  (result_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (step) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= result_next;
    end
  end

  assign out_valid = out_full;
  assign scl_out   = res_q.scl_out;
  assign sda_out   = res_q.sda_out;
  assign sda_drive = res_q.sda_drive;
  assign busy_res  = res_q.busy_res;
  assign done_res  = res_q.done_res;
  assign rx_data   = res_q.rx_data;
  assign no_ack    = res_q.no_ack;
  assign rejected  = res_q.rejected;

`ifndef SYNTHESIS
  // input side only backs up when the result side is stalled
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_stall)
    else $error("input stalled without output stall");

  // a finished sequence leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !busy_res)
    else $error("done reported while still busy");

  // a command is only turned away while a sequence runs
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rejected) |-> (busy_res && !done_res))
    else $error("rejected while idle or finishing");

  // a stalled result stays valid
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");
`endif

endmodule

// ===== design/i2cm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_core
// Sequencer state and its one-item update: applies a tick or command to the
// bus state and presents the resulting pin levels and status.
// ----------------------------------------------------------------------------
module i2cm_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  i2cm_pkg::item_t  item,
  input  logic [7:0]       ticks_per_us,
  input  logic [7:0]       ack_timeout,
  output i2cm_pkg::result_t result_next
);
  import i2cm_pkg::*;

  phase_t     phase, phase_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [3:0] us_count, us_count_next;
  logic [7:0] prescale_count, prescale_count_next;
  logic [7:0] poll_count, poll_count_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic       sda_enable, sda_enable_next;
  logic [7:0] rx_byte, rx_byte_next;
  logic       read_ack_choice, read_ack_choice_next;
  logic       timeout_flag, timeout_flag_next;

  logic       done;
  logic       rej;
  logic       adv;
  logic [7:0] tpu;
  logic [7:0] pre_inc;
  logic [3:0] us_inc;
  logic [3:0] bit_inc;

  // next state for one item
  always_comb begin
    phase_next           = phase;
    bit_index_next       = bit_index;
    shift_byte_next      = shift_byte;
    us_count_next        = us_count;
    prescale_count_next  = prescale_count;
    poll_count_next      = poll_count;
    scl_level_next       = scl_level;
    sda_level_next       = sda_level;
    sda_enable_next      = sda_enable;
    rx_byte_next         = rx_byte;
    read_ack_choice_next = read_ack_choice;
    timeout_flag_next    = timeout_flag;
    done    = 1'b0;
    rej     = 1'b0;
    adv     = 1'b0;
    tpu     = (ticks_per_us == 8'd0) ? 8'd1 : ticks_per_us;
    pre_inc = prescale_count + 8'd1;
    us_inc  = us_count + 4'd1;
    bit_inc = bit_index + 4'd1;

    if (item.kind == KIND_TICK || item.kind > KIND_WAIT_ACK) begin
      // time step
      if (phase == PH_WA_POLL) begin
        if (!item.sda_line) begin
          scl_level_next      = 1'b0;
          phase_next          = PH_IDLE;
          us_count_next       = 4'd0;
          prescale_count_next = 8'd0;
          done                = 1'b1;
        end else if (poll_count >= ack_timeout) begin
          // timed out: run a stop
          timeout_flag_next   = 1'b1;
          sda_enable_next     = 1'b1;
          scl_level_next      = 1'b0;
          sda_level_next      = 1'b0;
          phase_next          = PH_STO_A;
          us_count_next       = 4'd0;
          prescale_count_next = 8'd0;
        end else begin
          poll_count_next = poll_count + 8'd1;
        end
      end else if (phase != PH_IDLE) begin
        if (pre_inc < tpu) begin
          prescale_count_next = pre_inc;
        end else begin
          prescale_count_next = 8'd0;
          if (us_inc < phase_delay(phase)) begin
            us_count_next = us_inc;
          end else begin
            us_count_next = 4'd0;
            adv           = 1'b1;
          end
        end
      end
    end else if (phase != PH_IDLE) begin
      rej = 1'b1;
    end else begin
      // command from idle
      us_count_next       = 4'd0;
      prescale_count_next = 8'd0;
      case (item.kind)
        KIND_START: begin
          sda_enable_next = 1'b1;
          sda_level_next  = 1'b1;
          scl_level_next  = 1'b1;
          phase_next      = PH_STA_A;
        end
        KIND_STOP: begin
          sda_enable_next = 1'b1;
          scl_level_next  = 1'b0;
          sda_level_next  = 1'b0;
          phase_next      = PH_STO_A;
        end
        KIND_WRITE: begin
          sda_enable_next = 1'b1;
          scl_level_next  = 1'b0;
          bit_index_next  = 4'd0;
          sda_level_next  = item.tx_data[7];
          shift_byte_next = {item.tx_data[6:0], 1'b0};
          phase_next      = PH_WR_LOW;
        end
        KIND_READ: begin
          sda_enable_next      = 1'b0;
          scl_level_next       = 1'b0;
          shift_byte_next      = 8'd0;
          bit_index_next       = 4'd0;
          read_ack_choice_next = item.ack_after_read;
          phase_next           = PH_RD_LOW;
        end
        default: begin
          sda_enable_next   = 1'b0;
          sda_level_next    = 1'b1;
          timeout_flag_next = 1'b0;
          poll_count_next   = 8'd0;
          phase_next        = PH_WA_A;
        end
      endcase
    end

    // end of a timed step
    if (adv) begin
      case (phase)
        PH_STA_A: begin
          sda_level_next = 1'b0;
          phase_next     = PH_STA_B;
        end
        PH_STA_B: begin
          scl_level_next = 1'b0;
          phase_next     = PH_IDLE;
          done           = 1'b1;
        end
        PH_STO_A: begin
          scl_level_next = 1'b1;
          sda_level_next = 1'b1;
          phase_next     = PH_STO_B;
        end
        PH_STO_B: begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
        PH_WA_A: begin
          scl_level_next = 1'b1;
          phase_next     = PH_WA_B;
        end
        PH_WA_B: begin
          phase_next = PH_WA_POLL;
        end
        PH_WR_LOW: begin
          scl_level_next = 1'b1;
          phase_next     = PH_WR_HIGH;
        end
        PH_WR_HIGH: begin
          scl_level_next = 1'b0;
          bit_index_next = bit_inc;
          if (bit_inc >= BYTE_BITS) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else begin
            sda_level_next  = shift_byte[7];
            shift_byte_next = {shift_byte[6:0], 1'b0};
            phase_next      = PH_WR_LOW;
          end
        end
        PH_RD_LOW: begin
          scl_level_next  = 1'b1;
          shift_byte_next = {shift_byte[6:0], item.sda_line};
          phase_next      = PH_RD_HIGH;
        end
        PH_RD_HIGH: begin
          bit_index_next = bit_inc;
          scl_level_next = 1'b0;
          if (bit_inc < BYTE_BITS) begin
            phase_next = PH_RD_LOW;
          end else begin
            sda_enable_next = 1'b1;
            sda_level_next  = !read_ack_choice;
            phase_next      = PH_RA_LOW;
          end
        end
        PH_RA_LOW: begin
          scl_level_next = 1'b1;
          phase_next     = PH_RA_HIGH;
        end
        PH_RA_HIGH: begin
          scl_level_next = 1'b0;
          rx_byte_next   = shift_byte;
          phase_next     = PH_IDLE;
          done           = 1'b1;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // result as seen after this item
  always_comb begin
    result_next.scl_out   = scl_level_next;
    result_next.sda_out   = sda_level_next;
    result_next.sda_drive = sda_enable_next;
    result_next.busy_res  = (phase_next != PH_IDLE);
    result_next.done_res  = done;
    result_next.rx_data   = rx_byte_next;
    result_next.no_ack    = timeout_flag_next;
    result_next.rejected  = rej;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_index       <= 4'd0;
      shift_byte      <= 8'd0;
      us_count        <= 4'd0;
      prescale_count  <= 8'd0;
      poll_count      <= 8'd0;
      scl_level       <= 1'b1;
      sda_level       <= 1'b1;
      sda_enable      <= 1'b1;
      rx_byte         <= 8'd0;
      read_ack_choice <= 1'b0;
      timeout_flag    <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      bit_index       <= bit_index_next;
      shift_byte      <= shift_byte_next;
      us_count        <= us_count_next;
      prescale_count  <= prescale_count_next;
      poll_count      <= poll_count_next;
      scl_level       <= scl_level_next;
      sda_level       <= sda_level_next;
      sda_enable      <= sda_enable_next;
      rx_byte         <= rx_byte_next;
      read_ack_choice <= read_ack_choice_next;
      timeout_flag    <= timeout_flag_next;
    end
  end

endmodule

// ===== tb/i2c_master_bit_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_tb
// Self-checking bench for the i2c master bit sequencer. A generator fills a
// queue with bus commands and tick streams: directed corner cases first, then
// random start/write/ack/read/stop transactions under three idling mixes. A
// clocked driver sends them, a built-in model of the sequencer predicts the
// pin levels and status of every transfer, and a clocked monitor compares
// each returned status field by field in order.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_tb;
  import i2cm_pkg::*;

  // unused command codes, both behave as tick
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  item_t      drv_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_out, sda_out, sda_drive, busy_res, done_res, no_ack, rejected;
  logic [7:0] rx_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = '0;

  // commands waiting to be sent and statuses waiting to come back
  item_t   bus_cmds[$];
  result_t predicted_status[$];

  int unsigned send_idle_pct = 16;
  int unsigned recv_stall_pct = 72;
  int n_errors = 0;
  int n_pushed = 0;
  int n_items = 0;
  int n_done = 0;
  int n_rejected = 0;
  int n_timeouts = 0;
  int n_cfg = 0;

  // model state of the sequencer
  phase_t     ph;
  logic [3:0] bit_idx;
  logic [7:0] shreg;
  logic [3:0] us_cnt;
  logic [7:0] pre_cnt;
  logic [7:0] poll_cnt;
  logic       scl_q, sda_q, sda_en;
  logic [7:0] rx_q;
  logic       ack_choice;
  logic       timed_out;
  logic [7:0] tpu_reg;
  logic [7:0] timeout_reg;

  result_t pred;
  result_t want;

  i2c_master_bit_sequencer dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (drv_item.kind),
    .tx_data       (drv_item.tx_data),
    .ack_after_read(drv_item.ack_after_read),
    .sda_line      (drv_item.sda_line),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .scl_out       (scl_out),
    .sda_out       (sda_out),
    .sda_drive     (sda_drive),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .rx_data       (rx_data),
    .no_ack        (no_ack),
    .rejected      (rejected),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------- sequencer model ----------------

  function automatic void bus_enter(phase_t p);
    ph = p;
    us_cnt = '0;
    pre_cnt = '0;
  endfunction

  function automatic void bus_begin_stop();
    sda_en = 1'b1;
    scl_q = 1'b0;
    sda_q = 1'b0;
    bus_enter(PH_STO_A);
  endfunction

  // present the next data bit msb first
  function automatic void load_next_bit();
    sda_q = shreg[7];
    shreg = {shreg[6:0], 1'b0};
    bus_enter(PH_WR_LOW);
  endfunction

  // one tick of bus time, returns 1 when a sequence finishes
  function automatic logic bus_tick(logic sda);
    logic [7:0] per_us;
    logic [3:0] hold;
    per_us = (tpu_reg == 8'd0) ? 8'd1 : tpu_reg;
    if (ph == PH_IDLE) return 1'b0;
    // ack polling runs once per tick, no prescaler
    if (ph == PH_WA_POLL) begin
      if (!sda) begin
        scl_q = 1'b0;
        bus_enter(PH_IDLE);
        return 1'b1;
      end
      if (poll_cnt >= timeout_reg) begin
        timed_out = 1'b1;
        n_timeouts++;
        bus_begin_stop();
        return 1'b0;
      end
      poll_cnt++;
      return 1'b0;
    end
    pre_cnt++;
    if (pre_cnt < per_us) return 1'b0;
    pre_cnt = '0;
    us_cnt++;
    case (ph)
      PH_STA_A, PH_STA_B, PH_STO_A, PH_STO_B: hold = 4'd4;
      PH_WA_A, PH_WA_B:                       hold = 4'd1;
      PH_RA_LOW, PH_RA_HIGH:                  hold = 4'd2;
      default:                                hold = 4'd5;
    endcase
    if (us_cnt < hold) return 1'b0;
    us_cnt = '0;
    // step finished, take the next bus action
    case (ph)
      PH_STA_A: begin
        sda_q = 1'b0;
        bus_enter(PH_STA_B);
      end
      PH_STA_B: begin
        scl_q = 1'b0;
        bus_enter(PH_IDLE);
        return 1'b1;
      end
      PH_STO_A: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
        bus_enter(PH_STO_B);
      end
      PH_STO_B: begin
        bus_enter(PH_IDLE);
        return 1'b1;
      end
      PH_WA_A: begin
        scl_q = 1'b1;
        bus_enter(PH_WA_B);
      end
      PH_WA_B: bus_enter(PH_WA_POLL);
      PH_WR_LOW: begin
        scl_q = 1'b1;
        bus_enter(PH_WR_HIGH);
      end
      PH_WR_HIGH: begin
        scl_q = 1'b0;
        bit_idx++;
        if (bit_idx >= BYTE_BITS) begin
          bus_enter(PH_IDLE);
          return 1'b1;
        end
        load_next_bit();
      end
      PH_RD_LOW: begin
        scl_q = 1'b1;
        shreg = {shreg[6:0], sda};
        bus_enter(PH_RD_HIGH);
      end
      PH_RD_HIGH: begin
        bit_idx++;
        scl_q = 1'b0;
        if (bit_idx < BYTE_BITS) begin
          bus_enter(PH_RD_LOW);
        end else begin
          sda_en = 1'b1;
          sda_q = !ack_choice;
          bus_enter(PH_RA_LOW);
        end
      end
      PH_RA_LOW: begin
        scl_q = 1'b1;
        bus_enter(PH_RA_HIGH);
      end
      PH_RA_HIGH: begin
        scl_q = 1'b0;
        rx_q = shreg;
        bus_enter(PH_IDLE);
        return 1'b1;
      end
      default: bus_enter(PH_IDLE);
    endcase
    return 1'b0;
  endfunction

  // pin levels and status after one command or tick
  function automatic result_t next_bus_status(item_t it);
    result_t r;
    logic fin;
    logic rej;
    fin = 1'b0;
    rej = 1'b0;
    if (it.kind == KIND_TICK || it.kind > KIND_WAIT_ACK) begin
      fin = bus_tick(it.sda_line);
    end else if (ph != PH_IDLE) begin
      rej = 1'b1;
    end else begin
      case (it.kind)
        KIND_START: begin
          sda_en = 1'b1;
          sda_q = 1'b1;
          scl_q = 1'b1;
          bus_enter(PH_STA_A);
        end
        KIND_STOP: bus_begin_stop();
        KIND_WRITE: begin
          sda_en = 1'b1;
          scl_q = 1'b0;
          shreg = it.tx_data;
          bit_idx = '0;
          load_next_bit();
        end
        KIND_READ: begin
          sda_en = 1'b0;
          scl_q = 1'b0;
          shreg = '0;
          bit_idx = '0;
          ack_choice = it.ack_after_read;
          bus_enter(PH_RD_LOW);
        end
        default: begin
          sda_en = 1'b0;
          sda_q = 1'b1;
          timed_out = 1'b0;
          poll_cnt = '0;
          bus_enter(PH_WA_A);
        end
      endcase
    end
    r.scl_out = scl_q;
    r.sda_out = sda_q;
    r.sda_drive = sda_en;
    r.busy_res = (ph != PH_IDLE);
    r.done_res = fin;
    r.rx_data = rx_q;
    r.no_ack = timed_out;
    r.rejected = rej;
    return r;
  endfunction

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // transfer at this edge: predict its status
      if (in_valid && !in_stall) begin
        pred = next_bus_status(drv_item);
        predicted_status.push_back(pred);
        n_items++;
        if (pred.done_res) n_done++;
        if (pred.rejected) n_rejected++;
      end
      if (!in_valid || !in_stall) begin
        if (bus_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item <= bus_cmds.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        if (predicted_status.size() == 0) begin
          $error("status transfer with nothing outstanding");
          n_errors++;
        end else begin
          want = predicted_status.pop_front();
          check_field("scl_out", 8'(want.scl_out), 8'(scl_out));
          check_field("sda_out", 8'(want.sda_out), 8'(sda_out));
          check_field("sda_drive", 8'(want.sda_drive), 8'(sda_drive));
          check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
          check_field("done_res", 8'(want.done_res), 8'(done_res));
          check_field("rx_data", want.rx_data, rx_data);
          check_field("no_ack", 8'(want.no_ack), 8'(no_ack));
          check_field("rejected", 8'(want.rejected), 8'(rejected));
        end
      end
    end
  end

  // ---------------- stimulus ----------------

  task automatic push_cmd(logic [2:0] k, logic [7:0] d, logic a);
    item_t it;
    it.kind = k;
    it.tx_data = d;
    it.ack_after_read = a;
    it.sda_line = 1'($urandom_range(1));
    bus_cmds.push_back(it);
    n_pushed++;
  endtask

  // ticks with random sda, now and then as a spare code
  task automatic push_ticks(int n);
    logic [2:0] k;
    repeat (n) begin
      case ($urandom_range(15))
        0:       k = KIND_SPARE_A;
        1:       k = KIND_SPARE_B;
        default: k = KIND_TICK;
      endcase
      push_cmd(k, 8'($urandom), 1'($urandom_range(1)));
    end
  endtask

  // ticks with sda held at one level
  task automatic push_line(int n, logic level);
    repeat (n) begin
      push_cmd(KIND_TICK, 8'($urandom), 1'($urandom_range(1)));
      bus_cmds[bus_cmds.size() - 1].sda_line = level;
    end
  endtask

  function automatic int us_ticks(int us);
    return us * ((tpu_reg == 8'd0) ? 1 : int'(tpu_reg));
  endfunction

  // ticks for a step, sometimes cut short so the next command is turned away
  function automatic int tick_budget(int us);
    int base;
    base = us_ticks(us);
    if ($urandom_range(9) == 0) return int'($urandom_range(base - 1));
    return base + int'($urandom_range(2));
  endfunction

  task automatic push_ack_wait();
    int highs;
    push_cmd(KIND_WAIT_ACK, 8'($urandom), 1'($urandom_range(1)));
    push_ticks(tick_budget(2));
    if ($urandom_range(4) == 0) begin
      // slave never answers: timeout then stop
      push_line(int'(timeout_reg) + 1, 1'b1);
      push_ticks(tick_budget(8));
    end else begin
      if ($urandom_range(3) == 0) highs = int'(timeout_reg);
      else highs = int'($urandom_range((timeout_reg < 8'd6) ? int'(timeout_reg) : 6));
      push_line(highs, 1'b1);
      push_line(1, 1'b0);
    end
  endtask

  task automatic gen_transaction();
    push_cmd(KIND_START, 8'($urandom), 1'($urandom_range(1)));
    push_ticks(tick_budget(8));
    repeat ($urandom_range(1, 2)) begin
      case ($urandom_range(7))
        0, 1, 2: begin
          push_cmd(KIND_WRITE, 8'($urandom), 1'($urandom_range(1)));
          push_ticks(tick_budget(80));
          push_ack_wait();
        end
        3, 4, 5: begin
          push_cmd(KIND_READ, 8'($urandom), 1'($urandom_range(1)));
          push_ticks(tick_budget(84));
        end
        6: push_ack_wait();
        default: begin
          // stray command of any code
          push_cmd(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)));
          push_ticks($urandom_range(6));
        end
      endcase
    end
    push_cmd(KIND_STOP, 8'($urandom), 1'($urandom_range(1)));
    push_ticks(tick_budget(8));
  endtask

  // sender holds off until every status has come back
  task automatic drain();
    while (bus_cmds.size() != 0 || in_valid || predicted_status.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    drain();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TICKS_PER_US) tpu_reg = val;
    else timeout_reg = val;
    n_cfg++;
  endtask

  task automatic run_random_phase(int unsigned sender_idle, int unsigned receiver_stall);
    int first;
    write_reg(REG_TICKS_PER_US, 8'($urandom_range(1, 2)));
    write_reg(REG_ACK_TIMEOUT, 8'($urandom_range(1, 24)));
    send_idle_pct = sender_idle;
    recv_stall_pct = receiver_stall;
    first = n_pushed;
    while (n_pushed - first < 40) gen_transaction();
    drain();
    while (n_pushed - first < 80) gen_transaction();
  endtask

  initial begin
    // model reset state
    ph = PH_IDLE;
    bit_idx = '0;
    shreg = '0;
    us_cnt = '0;
    pre_cnt = '0;
    poll_cnt = '0;
    scl_q = 1'b1;
    sda_q = 1'b1;
    sda_en = 1'b1;
    rx_q = '0;
    ack_choice = 1'b0;
    timed_out = 1'b0;
    tpu_reg = TICKS_PER_US_RESET;
    timeout_reg = ACK_TIMEOUT_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // idle ticks, spare codes, commands while busy
    push_cmd(KIND_TICK, 8'h00, 1'b0);
    push_cmd(KIND_SPARE_A, 8'hff, 1'b1);
    push_cmd(KIND_SPARE_B, 8'h5a, 1'b0);
    push_cmd(KIND_START, 8'h00, 1'b0);
    push_cmd(KIND_STOP, 8'h00, 1'b0);
    push_cmd(KIND_READ, 8'hff, 1'b1);
    push_ticks(8);
    // all-ones byte, ack after a few high polls
    push_cmd(KIND_WRITE, 8'hff, 1'b1);
    push_ticks(80);
    push_cmd(KIND_WAIT_ACK, 8'hff, 1'b1);
    push_ticks(2);
    push_line(3, 1'b1);
    push_line(1, 1'b0);
    // read of all ones with ack
    push_cmd(KIND_READ, 8'h00, 1'b1);
    push_line(84, 1'b1);
    push_cmd(KIND_STOP, 8'h00, 1'b0);
    push_ticks(8);

    // zero rate counts as one, zero timeout fails on first high poll
    write_reg(REG_TICKS_PER_US, 8'd0);
    write_reg(REG_ACK_TIMEOUT, 8'd0);
    push_cmd(KIND_WAIT_ACK, 8'h00, 1'b0);
    push_ticks(2);
    push_line(1, 1'b1);
    push_ticks(8);

    // slowest rate: one full prescaler count into the start hold
    write_reg(REG_TICKS_PER_US, 8'd255);
    push_cmd(KIND_START, 8'h00, 1'b0);
    push_ticks(us_ticks(1) + 1);

    run_random_phase(16, 72);
    run_random_phase(72, 16);
    run_random_phase(0, 0);

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d transfers and %0d register writes", n_items, n_cfg);
    $display("%0d sequences finished, %0d commands turned away, %0d ack timeouts",
             n_done, n_rejected, n_timeouts);
    if (n_errors == 0) begin
      $display("i2c_master_bit_sequencer: match");
    end else begin
      $display("i2c_master_bit_sequencer: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout waiting for the run to finish");
    $display("i2c_master_bit_sequencer: mismatch");
    $finish;
  end

endmodule

// ===== i2c_master_bit_sequencer.f =====
design/i2cm_pkg.sv
design/i2cm_core.sv
design/i2c_master_bit_sequencer.sv
tb/i2c_master_bit_sequencer_tb.sv
